// ===== hdl/bagtbl_pkg.sv =====
// bagtbl_pkg: shared types and constants for the bag table with search
// command and error codes, controller states and the cell control struct
// no dependencies
package bagtbl_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned CmdW        = 3;
  localparam int unsigned CountW      = 7;
  localparam int unsigned ErrW        = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 3'd0,
    CMD_POP    = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_QUERY  = 3'd4
  } cmd_e;

  typedef enum logic [ErrW-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_e;

  // control broadcast from the controller to every cell
  typedef struct packed {
    logic start;  // launch the search token into the first cell
    logic kill;   // drop every token in the chain
    logic shr;    // push: every entry moves one cell up, key enters cell 0
    logic shl;    // pull: every entry moves one cell down
    logic rmv;    // with shl: the target cell takes the old cell 0 entry
  } cell_ctl_t;

endpackage

// ===== hdl/bag_table_with_search.sv =====
// bag_table_with_search: unordered bag of 64-bit patterns held in a chain of cells
// controller, search accumulator and result register; instantiates bagtbl_cell
// depends on bagtbl_pkg
//
//  channel  valid       stall        payload
//  in       in_valid_i  in_stall_o   cmd_i, value_in_i
//  out      out_valid_o out_stall_i  value_out_o, found_o, frequency_o,
//                                    fill_count_o, error_code_o
//
// add, pop, clear and unused codes are carried out in the exec state, which loads the result.
// remove and query walk a token up the cell chain, one cell per cycle, over
// the held entries and load the result in the finish state; an empty bag skips the walk.
// cell 0 always holds the top of the bag, so pop and remove read it directly.
// reset empties the bag; entries need no clearing. one transaction in flight;
// a waiting result in the output register holds the next transaction in the
// controller, and the input stays stalled until that result is taken.
module bag_table_with_search import bagtbl_pkg::*; #(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ValueW-1:0] value_out_o,
  output logic              found_o,
  output logic [CountW-1:0] frequency_o,
  output logic [CountW-1:0] fill_count_o,
  output logic [ErrW-1:0]   error_code_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [ValueW-1:0] key_q;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]   freq_q, freq_d;
  logic              match_q, match_d;
  logic [IdxW-1:0]   last_q, last_d;

  logic              out_valid_q;
  logic [ValueW-1:0] vout_q, vout_d;
  logic              found_q, found_d;
  logic [CountW-1:0] fr_q, fr_d;
  logic [CountW-1:0] fill_q;
  err_e              err_q, err_d;

  logic              accept, out_free, load;
  logic              scan_cmd, scan_last, hit_any;
  logic [CntW-1:0]   count_m1;
  cell_ctl_t         ctl;
  logic [IdxW-1:0]   target;

  logic [ValueW-1:0] entry  [CAPACITY];
  logic [CAPACITY:0] token;
  logic [CAPACITY-1:0] hit;

  // cell chain
  assign token[0] = ctl.start;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValueW-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = key_q;
    end else begin : g_mid
      assign lower = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_low
      assign upper = entry[g+1];
    end

    bagtbl_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .target_i (target),
      .key_i    (key_q),
      .last_i   (entry[0]),
      .lower_i  (lower),
      .upper_i  (upper),
      .token_i  (token[g]),
      .token_o  (token[g+1]),
      .entry_o  (entry[g]),
      .hit_o    (hit[g])
    );
  end

  assign hit_any   = |hit;
  assign count_m1  = count_q - CntW'(1);
  assign scan_last = (idx_q == count_m1[IdxW-1:0]);
  assign scan_cmd  = ((cmd_q == CMD_REMOVE) || (cmd_q == CMD_QUERY)) && (count_q != '0);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  // removing the match at cell p: the chain pulls down and cell p-1 takes old cell 0
  assign target    = last_q - IdxW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (scan_cmd) begin
          state_d = ST_SCAN;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // controller outputs and datapath
  always_comb begin
    ctl     = '0;
    load    = 1'b0;
    count_d = count_q;
    idx_d   = idx_q;
    freq_d  = freq_q;
    match_d = match_q;
    last_d  = last_q;
    vout_d  = '0;
    found_d = 1'b0;
    fr_d    = '0;
    err_d   = ERR_OK;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          freq_d  = '0;
          match_d = 1'b0;
          last_d  = '0;
          idx_d   = '0;
        end
      end
      ST_EXEC: begin
        if (scan_cmd) begin
          ctl.start = 1'b1;
          idx_d     = '0;
        end else if (out_free) begin
          load = 1'b1;
          unique case (cmd_q)
            CMD_ADD: begin
              if (count_q == CntW'(CAPACITY)) begin
                err_d = ERR_FULL;
              end else begin
                ctl.shr = 1'b1;
                count_d = count_q + CntW'(1);
              end
            end
            CMD_POP: begin
              if (count_q == '0) begin
                err_d = ERR_EMPTY;
              end else begin
                ctl.shl = 1'b1;
                count_d = count_m1;
                vout_d  = entry[0];
              end
            end
            CMD_REMOVE: err_d = ERR_EMPTY;  // only reached when empty
            CMD_CLEAR:  count_d = '0;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          freq_d  = freq_q + CntW'(1);
          match_d = 1'b1;
          last_d  = idx_q;  // keep the highest matching cell, the one that remove takes out
        end
        if (scan_last) begin
          ctl.kill = 1'b1;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          load    = 1'b1;
          found_d = match_q;
          if (cmd_q == CMD_QUERY) begin
            fr_d = CountW'(freq_q);
          end else if (match_q) begin
            ctl.shl = 1'b1;
            ctl.rmv = (last_q != '0);
            count_d = count_m1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= value_in_i;
    end
    idx_q   <= idx_d;
    freq_q  <= freq_d;
    match_q <= match_d;
    last_q  <= last_d;
    if (load) begin
      vout_q  <= vout_d;
      found_q <= found_d;
      fr_q    <= fr_d;
      fill_q  <= CountW'(count_d);
      err_q   <= err_d;
    end
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_out_o  = vout_q;
  assign found_o      = found_q;
  assign frequency_o  = fr_q;
  assign fill_count_o = fill_q;
  assign error_code_o = err_q;

endmodule

// ===== hdl/bagtbl_cell.sv =====
// bagtbl_cell: one storage cell of the bag chain
// holds one entry and one search token, shifts both to its neighbours
// depends on bagtbl_pkg
module bagtbl_cell import bagtbl_pkg::*; #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [IdxW-1:0]   target_i,
  input  logic [ValueW-1:0] key_i,
  input  logic [ValueW-1:0] last_i,
  input  logic [ValueW-1:0] lower_i,
  input  logic [ValueW-1:0] upper_i,
  input  logic              token_i,
  output logic              token_o,
  output logic [ValueW-1:0] entry_o,
  output logic              hit_o
);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              token_q, token_d;
  logic              is_target;

  assign is_target = (target_i == IdxW'(CellIdx));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shr) begin
      entry_d = lower_i;
    end else if (ctl_i.shl) begin
      entry_d = (ctl_i.rmv && is_target) ? last_i : upper_i;
    end
  end

  assign token_d = ctl_i.kill ? 1'b0 : token_i;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
    end else begin
      token_q <= token_d;
    end
  end

  assign token_o = token_q;
  assign entry_o = entry_q;
  assign hit_o   = token_q && (entry_q == key_i);

endmodule

// ===== bench/bag_checker.sv =====
`timescale 1ns / 1ps
// bag_checker: watches both channels of the bag table, predicts each result and compares
// depends on bagtbl_pkg
module bag_checker import bagtbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_o,
  input  logic [CmdW-1:0]   cmd_i,
  input  logic [ValueW-1:0] value_in_i,
  input  logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic [ValueW-1:0] value_out_o,
  input  logic              found_o,
  input  logic [CountW-1:0] frequency_o,
  input  logic [CountW-1:0] fill_count_o,
  input  logic [ErrW-1:0]   error_code_o,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [ValueW-1:0] value_out;
    logic              found;
    logic [CountW-1:0] frequency;
    logic [CountW-1:0] fill_count;
    err_e              error_code;
  } bag_result_t;

  // predicted contents, bottom first; a pop takes the entry at the top
  logic [ValueW-1:0] bag_store [CapacityDef];
  int                bag_fill = 0;
  bag_result_t       expected_results [$];

  function automatic bag_result_t apply_command(logic [CmdW-1:0] cmd, logic [ValueW-1:0] value);
    bag_result_t r;
    int          idx;
    int          hits;
    r    = '0;
    hits = 0;
    case (cmd)
      CMD_ADD: begin
        if (bag_fill >= CapacityDef) begin
          r.error_code = ERR_FULL;
        end else begin
          bag_store[bag_fill] = value;
          bag_fill++;
        end
      end
      CMD_POP: begin
        if (bag_fill == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          bag_fill--;
          r.value_out = bag_store[bag_fill];
        end
      end
      CMD_REMOVE: begin
        if (bag_fill == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          // first match takes the last entry, then the bag shrinks
          for (idx = 0; idx < bag_fill && !r.found; idx++) begin
            if (bag_store[idx] == value) begin
              bag_store[idx] = bag_store[bag_fill-1];
              bag_fill--;
              r.found = 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        bag_fill = 0;
      end
      CMD_QUERY: begin
        for (idx = 0; idx < bag_fill; idx++) begin
          if (bag_store[idx] == value) hits++;
        end
        r.frequency = CountW'(hits);
        r.found     = (hits != 0);
      end
      default: begin
      end
    endcase
    r.fill_count = CountW'(bag_fill);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ValueW-1:0] got, logic [ValueW-1:0] want);
    $display("%0t bag_checker: %s got %h expected %h", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i) begin
    bag_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", value_out_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (value_out_o !== want.value_out)
            report_mismatch("value_out", value_out_o, want.value_out);
          if (found_o !== want.found)
            report_mismatch("found", ValueW'(found_o), ValueW'(want.found));
          if (frequency_o !== want.frequency)
            report_mismatch("frequency", ValueW'(frequency_o), ValueW'(want.frequency));
          if (fill_count_o !== want.fill_count)
            report_mismatch("fill_count", ValueW'(fill_count_o), ValueW'(want.fill_count));
          if (error_code_o !== want.error_code)
            report_mismatch("error_code", ValueW'(error_code_o), ValueW'(want.error_code));
        end
      end
      if (in_valid_i && !in_stall_o) expected_results.push_back(apply_command(cmd_i, value_in_i));
      pending_o <= expected_results.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: clock, reset, command stimulus and verdict for the bag table with search
// depends on bagtbl_pkg, bag_table_with_search and bag_checker
module testbench;
  import bagtbl_pkg::*;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic [CmdW-1:0]   cmd_i       = '0;
  logic [ValueW-1:0] value_in_i  = '0;
  logic              out_stall_i = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [ValueW-1:0] value_out_o;
  logic              found_o;
  logic [CountW-1:0] frequency_o;
  logic [CountW-1:0] fill_count_o;
  logic [ErrW-1:0]   error_code_o;

  int errors;
  int pending;
  int sent_count    = 0;
  int burst_left    = 0;
  bit pressure_done = 1'b0;

  always #5 clk_i = ~clk_i;

  bag_table_with_search uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_out_o (value_out_o),
    .found_o     (found_o),
    .frequency_o (frequency_o),
    .fill_count_o(fill_count_o),
    .error_code_o(error_code_o)
  );

  bag_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_out_o (value_out_o),
    .found_o     (found_o),
    .frequency_o (frequency_o),
    .fill_count_o(fill_count_o),
    .error_code_o(error_code_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // valid stays high from the previous transaction when there is no gap
  task automatic offer_command(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] value);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left == 0 && $urandom_range(0, 99) == 0) burst_left = $urandom_range(30, 80);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if (roll < 60) begin
      gap = 0;
    end else if (roll < 88) begin
      gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      gap = $urandom_range(4, 12);
    end else begin
      gap = $urandom_range(20, 40);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_in_i <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_count++;
  endtask

  // receiver: random stall bursts, one long hold-off to back the block up
  initial begin
    int run;
    int hold;
    int roll;
    @(posedge clk_i);
    forever begin
      if (!pressure_done && sent_count >= 400) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        pressure_done = 1'b1;
      end
      roll = $urandom_range(0, 99);
      run  = (roll < 10) ? $urandom_range(50, 100) : $urandom_range(1, 20);
      out_stall_i <= 1'b0;
      repeat (run) @(posedge clk_i);
      roll = $urandom_range(0, 99);
      if (roll < 70) hold = $urandom_range(1, 2);
      else if (roll < 95) hold = $urandom_range(3, 8);
      else hold = $urandom_range(20, 40);
      out_stall_i <= 1'b1;
      repeat (hold) @(posedge clk_i);
    end
  end

  initial begin
    logic [ValueW-1:0] value_pool [8];
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
    int                mode;
    int                roll;
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = 64'h8000_0000_0000_0000;
    for (int k = 3; k < 8; k++) value_pool[k] = {$urandom, $urandom};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty bag and unused codes
    offer_command(CMD_POP, '0);
    offer_command(CMD_REMOVE, '1);
    offer_command(CMD_QUERY, '0);
    offer_command(3'd5, 64'h0123_4567_89ab_cdef);
    offer_command(3'd6, '0);
    offer_command(3'd7, '1);
    // positive and negative zero, both nan forms, duplicates
    offer_command(CMD_ADD, '0);
    offer_command(CMD_ADD, '1);
    offer_command(CMD_ADD, 64'h8000_0000_0000_0000);
    offer_command(CMD_ADD, 64'h0000_0000_0000_0001);
    offer_command(CMD_ADD, '1);
    offer_command(CMD_ADD, 64'h7ff8_0000_0000_0000);
    offer_command(CMD_QUERY, '1);
    offer_command(CMD_QUERY, '0);
    offer_command(CMD_QUERY, 64'hfff8_0000_0000_0000);
    offer_command(CMD_QUERY, 64'h8000_0000_0000_0000);
    offer_command(CMD_REMOVE, 64'h5555_5555_5555_5555);
    offer_command(CMD_REMOVE, '0);
    offer_command(CMD_REMOVE, '1);
    offer_command(CMD_POP, '0);
    offer_command(3'd5, '1);
    offer_command(CMD_CLEAR, '1);
    offer_command(CMD_POP, '0);
    offer_command(CMD_ADD, 64'haaaa_aaaa_aaaa_aaaa);
    offer_command(CMD_POP, '0);

    // phases: grow to full, mixed, drain to empty, mixed
    for (int n = 0; n < 1450; n++) begin
      mode = (n / 120) % 4;
      roll = $urandom_range(0, 99);
      if (mode == 0) begin
        if (roll < 75) cmd = CMD_ADD;
        else if (roll < 80) cmd = CMD_POP;
        else if (roll < 85) cmd = CMD_REMOVE;
        else if (roll < 98) cmd = CMD_QUERY;
        else cmd = CmdW'($urandom_range(5, 7));
      end else if (mode == 2) begin
        if (roll < 10) cmd = CMD_ADD;
        else if (roll < 45) cmd = CMD_POP;
        else if (roll < 80) cmd = CMD_REMOVE;
        else if (roll < 97) cmd = CMD_QUERY;
        else cmd = CmdW'($urandom_range(5, 7));
      end else begin
        if (roll < 35) cmd = CMD_ADD;
        else if (roll < 50) cmd = CMD_POP;
        else if (roll < 70) cmd = CMD_REMOVE;
        else if (roll < 94) cmd = CMD_QUERY;
        else if (roll < 96) cmd = CMD_CLEAR;
        else cmd = CmdW'($urandom_range(5, 7));
      end
      // mostly a small set of patterns so that duplicates and matches are common
      if ($urandom_range(0, 9) < 7) value = value_pool[$urandom_range(0, 7)];
      else value = {$urandom, $urandom};
      offer_command(cmd, value);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (CapacityDef + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bagtbl_pkg.sv
hdl/bagtbl_cell.sv
hdl/bag_table_with_search.sv
bench/bag_checker.sv
bench/testbench.sv
